>>> design/rcdt_pkg.sv
// shared types and constants for the rc discharge timing capture block
// no dependencies
package rcdt_pkg;

  localparam int SLOTS      = 8;
  localparam int PIN_BITS   = 8;
  localparam int STAMP_BITS = 16;
  localparam int OUT_BITS   = 16;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef logic [PIN_BITS-1:0]   pins_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [OUT_BITS-1:0]   time_t;

  typedef struct packed {
    logic frame_tick;
    logic sample;
  } lane_ctrl_t;

endpackage

>>> design/rcdt_if.sv
// valid/ready channel interfaces for input items and result items
// depends on rcdt_pkg
interface rcdt_in_if;
  import rcdt_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  pins_t   pin_levels;
  stamp_t  timestamp;

  modport source (output valid, output action, output pin_levels, output timestamp,
                  input ready);
  modport sink (input valid, input action, input pin_levels, input timestamp,
                output ready);
endinterface

interface rcdt_out_if;
  import rcdt_pkg::*;

  logic  valid;
  logic  ready;
  time_t time_0;
  time_t time_1;
  time_t time_2;
  time_t time_3;
  time_t time_4;
  time_t time_5;
  time_t time_6;
  time_t time_7;

  modport source (output valid, output time_0, output time_1, output time_2,
                  output time_3, output time_4, output time_5, output time_6,
                  output time_7, input ready);
  modport sink (input valid, input time_0, input time_1, input time_2,
                input time_3, input time_4, input time_5, input time_6,
                input time_7, output ready);
endinterface

>>> design/rcdt_lane.sv
// one sensor channel: pending flag, last edge time and latched time
// depends on rcdt_pkg
module rcdt_lane #(
  parameter int TW = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rcdt_pkg::lane_ctrl_t ctrl,
  input  logic                pin,
  input  logic [TW-1:0]       stamp,
  output logic [TW-1:0]       latched
);
  import rcdt_pkg::*;

  logic          pending;
  logic [TW-1:0] edge_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      edge_time <= '0;
      latched   <= '0;
    end else if (ctrl.frame_tick) begin
      pending <= 1'b1;
      latched <= pending ? {TW{1'b1}} : edge_time;
    end else if (ctrl.sample) begin
      pending <= pin;
      if (pending && !pin) begin
        edge_time <= stamp;
      end
    end
  end

endmodule

>>> design/rcdt_merge.sv
// merge stage: reverses channel order into one result and buffers it
// in an output register with a skid entry; depends on rcdt_pkg, rcdt_if
module rcdt_merge #(
  parameter int CHANNELS = 8,
  parameter int TW       = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [TW-1:0] latched [CHANNELS],
  output logic          full,
  rcdt_out_if.source    result
);
  import rcdt_pkg::*;

  time_t res      [SLOTS];
  time_t out_q    [SLOTS];
  time_t skid_q   [SLOTS];
  logic  out_valid;
  logic  skid_valid;
  logic  pop;

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      res[k] = '0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      res[SLOTS-1-c] = time_t'(latched[c]);
    end
  end

  assign pop  = out_valid && result.ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      if (push) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_q <= res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_q     <= res;
      skid_valid <= 1'b1;
    end
  end

  assign result.valid  = out_valid;
  assign result.time_0 = out_q[0];
  assign result.time_1 = out_q[1];
  assign result.time_2 = out_q[2];
  assign result.time_3 = out_q[3];
  assign result.time_4 = out_q[4];
  assign result.time_5 = out_q[5];
  assign result.time_6 = out_q[6];
  assign result.time_7 = out_q[7];

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid entry without output entry");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid)) else $error("read pushed into full buffer");
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push && !out_valid |=> out_valid) else $error("pushed read not presented");
`endif

endmodule

>>> design/rc_discharge_timing_capture.sv
// rc discharge timer top level: action decode, capture arm flag, per-channel lanes, merge stage
// one item accepted per cycle unless the input stalls; each accepted read result is registered
// a read's result is shown from the output register; a second entry lets input continue
// input stalls only when both output entries hold untaken results
// synchronous reset clears pending flags, arm flag, edge and latched times
// depends on rcdt_pkg, rcdt_if, rcdt_lane, rcdt_merge
module rc_discharge_timing_capture #(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  rcdt_in_if.sink  item,
  rcdt_out_if.source result
);
  import rcdt_pkg::*;

  localparam int TW = (TIME_BITS < STAMP_BITS) ? TIME_BITS : STAMP_BITS;

  logic          accept;
  logic          armed;
  logic          full;
  logic          push;
  lane_ctrl_t    lane_ctrl;
  logic [TW-1:0] latched [CHANNELS];

  assign item.ready = !full;
  assign accept     = item.valid && item.ready;

  assign lane_ctrl.frame_tick = accept && (item.action == ACT_TICK);
  assign lane_ctrl.sample     = accept && (item.action == ACT_SAMPLE) && armed;
  assign push                 = accept && (item.action == ACT_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
    end else if (lane_ctrl.frame_tick) begin
      armed <= 1'b0;
    end else if (accept && (item.action == ACT_ARM)) begin
      armed <= 1'b1;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    rcdt_lane #(.TW(TW)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .pin     (item.pin_levels[c]),
      .stamp   (item.timestamp[TW-1:0]),
      .latched (latched[c])
    );
  end

  rcdt_merge #(.CHANNELS(CHANNELS), .TW(TW)) u_merge (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .latched (latched),
    .full    (full),
    .result  (result)
  );

`ifndef SYNTH
  a_sample_armed: assert property (@(posedge clk) disable iff (rst)
    lane_ctrl.sample |-> armed) else $error("sample taken while disarmed");
  a_tick_disarms: assert property (@(posedge clk) disable iff (rst)
    lane_ctrl.frame_tick |=> !armed) else $error("frame tick left capture armed");
  a_ctrl_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({lane_ctrl.frame_tick, lane_ctrl.sample, push}))
    else $error("more than one action decoded");
`endif

endmodule

>>> tb/rcdt_readout_scoreboard_pkg.sv
// readout scoreboard for the rc discharge timing capture testbench: tracks
// pending flags, edge and latched times and queues the expected readouts
// depends on rcdt_pkg
package rcdt_readout_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import rcdt_pkg::*;

  typedef logic [SLOTS-1:0][OUT_BITS-1:0] readout_t;

  class readout_scoreboard;
    pins_t    pend;
    logic     armed;
    stamp_t   fall_time [SLOTS];
    stamp_t   frame_time [SLOTS];
    readout_t expected_readouts [$];
    int       mismatches;
    int       reads_checked;
    int       samples_taken;
    int       edges_recorded;

    function new();
      pend = '0;
      armed = 1'b0;
      foreach (fall_time[i]) begin
        fall_time[i] = '0;
        frame_time[i] = '0;
      end
      mismatches = 0;
      reads_checked = 0;
      samples_taken = 0;
      edges_recorded = 0;
    endfunction

    function int outstanding();
      return expected_readouts.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH: %s", msg);
    endtask

    task note_item(action_t act, pins_t pins, stamp_t stamp);
      pins_t    fell;
      readout_t r;
      case (act)
        ACT_TICK: begin
          foreach (frame_time[i]) frame_time[i] = pend[i] ? '1 : fall_time[i];
          pend = '1;
          armed = 1'b0;
        end
        ACT_ARM: begin
          armed = 1'b1;
        end
        ACT_SAMPLE: begin
          if (armed) begin
            fell = ~pins & pend;
            for (int i = 0; i < SLOTS; i++) begin
              if (fell[i]) fall_time[i] = stamp;
            end
            pend = pins;
            samples_taken++;
            edges_recorded += $countones(fell);
          end
        end
        ACT_READ: begin
          for (int k = 0; k < SLOTS; k++) r[k] = frame_time[SLOTS-1-k];
          expected_readouts.push_back(r);
        end
      endcase
    endtask

    task check_readout(readout_t got);
      readout_t want;
      if (expected_readouts.size() == 0) begin
        report($sformatf("readout %h with no read outstanding", got));
        return;
      end
      want = expected_readouts.pop_front();
      for (int k = 0; k < SLOTS; k++) begin
        if (got[k] !== want[k])
          report($sformatf("readout %0d: time_%0d got %h want %h", reads_checked, k,
                           got[k], want[k]));
      end
      reads_checked++;
    endtask
  endclass

endpackage

>>> tb/tb_rc_discharge_timing_capture.sv
// testbench top for rc_discharge_timing_capture: directed and random frames of
// tick, arm, sample and read transactions with random idling on both channels
// depends on rcdt_pkg, rcdt_if and rcdt_readout_scoreboard_pkg
module tb_rc_discharge_timing_capture;
  timeunit 1ns;
  timeprecision 1ps;
  import rcdt_pkg::*;
  import rcdt_readout_scoreboard_pkg::*;

  logic clk;
  logic rst;

  rcdt_in_if  item_ch ();
  rcdt_out_if result_ch ();

  rc_discharge_timing_capture #(
    .CHANNELS  (SLOTS),
    .TIME_BITS (STAMP_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source)
  );

  readout_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_len     = 0;
  int hold_seq     = 0;
  int sent         = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
      sb.check_readout({result_ch.time_7, result_ch.time_6, result_ch.time_5,
                        result_ch.time_4, result_ch.time_3, result_ch.time_2,
                        result_ch.time_1, result_ch.time_0});
  end

  task automatic send_item(action_t act, pins_t pins, stamp_t stamp);
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= act;
    item_ch.pin_levels <= pins;
    item_ch.timestamp  <= stamp;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    sb.note_item(act, pins, stamp);
    sent++;
  endtask

  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  task automatic run_frame();
    pins_t  lv;
    stamp_t ts;
    int     kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      send_item(ACT_TICK, pins_t'($urandom), stamp_t'($urandom));
      if ($urandom_range(0, 7) != 0) send_item(ACT_ARM, pins_t'($urandom), stamp_t'($urandom));
      lv = '1;
      ts = stamp_t'($urandom);
      repeat ($urandom_range(1, 16)) begin
        ts = ts + stamp_t'($urandom_range(1, 400));
        lv = lv & pins_t'($urandom | $urandom);
        // a pin that bounces back high becomes pending again
        if ($urandom_range(0, 7) == 0) lv[$urandom_range(0, SLOTS-1)] = 1'b1;
        send_item(ACT_SAMPLE, lv, ts);
      end
      send_item(ACT_TICK, pins_t'($urandom), stamp_t'($urandom));
      repeat ($urandom_range(1, 2)) send_item(ACT_READ, pins_t'($urandom), stamp_t'($urandom));
    end else begin
      repeat ($urandom_range(3, 10))
        send_item(action_t'($urandom_range(0, 3)), pins_t'($urandom), stamp_t'($urandom));
    end
  endtask

  initial begin
    int tx_pct [3];
    int rx_pct [3];
    tx_pct = '{30, 47, 0};
    rx_pct = '{47, 30, 0};
    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.action     <= ACT_TICK;
    item_ch.pin_levels <= '0;
    item_ch.timestamp  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state, full fall, disarmed sample, alternating channels, bounce
    send_item(ACT_READ,   8'h00, 16'h0000);
    send_item(ACT_TICK,   8'h00, 16'h0000);
    send_item(ACT_READ,   8'hFF, 16'hFFFF);
    send_item(ACT_ARM,    8'h00, 16'h0000);
    send_item(ACT_SAMPLE, 8'hFF, 16'h1234);
    send_item(ACT_SAMPLE, 8'h00, 16'hFFFF);
    send_item(ACT_TICK,   8'hFF, 16'hFFFF);
    send_item(ACT_READ,   8'h00, 16'h0000);
    send_item(ACT_SAMPLE, 8'h00, 16'h0001);
    send_item(ACT_ARM,    8'hFF, 16'hFFFF);
    send_item(ACT_SAMPLE, 8'h55, 16'h0000);
    send_item(ACT_SAMPLE, 8'hAA, 16'h8000);
    send_item(ACT_SAMPLE, 8'hFF, 16'h7FFF);
    send_item(ACT_SAMPLE, 8'h7F, 16'hABCD);
    send_item(ACT_TICK,   8'h00, 16'h0000);
    send_item(ACT_READ,   8'h00, 16'h0000);
    send_item(ACT_ARM,    8'h00, 16'h0000);
    send_item(ACT_ARM,    8'h00, 16'h0000);
    send_item(ACT_TICK,   8'h00, 16'h0000);
    send_item(ACT_TICK,   8'h00, 16'h0000);
    send_item(ACT_READ,   8'h00, 16'h0000);
    wait_drain();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct  = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      if (p == 2) begin
        // receiver blocked while reads keep coming, so the input stalls
        hold_len = 80;
        hold_seq++;
        repeat (12) send_item(ACT_READ, pins_t'($urandom), stamp_t'($urandom));
        wait_drain();
      end
      while (sent < 21 + 410 * (p + 1)) run_frame();
      wait_drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d transactions: %0d armed samples, %0d falling edges recorded",
             sent, sb.samples_taken, sb.edges_recorded);
    $display("%0d readouts compared, %0d mismatches", sb.reads_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("watchdog expired with %0d readouts outstanding", sb.outstanding());
    $display("Some tests failed");
    $finish;
  end

endmodule
